### hdl/rbst_pkg.sv
// Package for the ray/box slab test: widths, register indexes and pipeline types.
// Used by the ray input and configuration interfaces and the top level.
package rbst_pkg;

  localparam int DATA_W        = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_AXES      = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Z = 3'd5;

  // Side data that travels alongside the dividers
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] near_v;
    logic signed [DATA_W-1:0] far_v;
    logic [NUM_AXES-1:0]      zero;
    logic [NUM_AXES-1:0]      inslab;
    logic [2*NUM_AXES-1:0]    neg;
  } side_t;

endpackage

### hdl/rbst_in_if.sv
// Ray input channel: valid/ready handshake and ray payload.
// Depends on rbst_pkg.
interface rbst_in_if import rbst_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] origin_x;
  logic signed [DATA_W-1:0] origin_y;
  logic signed [DATA_W-1:0] origin_z;
  logic signed [DATA_W-1:0] dir_x;
  logic signed [DATA_W-1:0] dir_y;
  logic signed [DATA_W-1:0] dir_z;
  logic signed [DATA_W-1:0] near_limit;
  logic signed [DATA_W-1:0] far_limit;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  near_limit, far_limit, input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                near_limit, far_limit, output ready);
endinterface

### hdl/rbst_out_if.sv
// Result channel: valid/ready handshake and hit flag.
// No dependencies.
interface rbst_out_if;
  logic valid;
  logic ready;
  logic is_hit;

  modport source (output valid, is_hit, input ready);
  modport sink (input valid, is_hit, output ready);
endinterface

### hdl/rbst_cfg_if.sv
// Configuration write channel: valid/ready, register index and write data.
// Depends on rbst_pkg.
interface rbst_cfg_if import rbst_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/rbst_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Standalone; instantiated by ray_box_slab_test.
module rbst_div #(
  parameter int NUM_W = 49,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o
);

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [NUM_W-1:0] num_in;
    logic [NUM_W-1:0] quo_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W-1:0] rem_r;
    logic [NUM_W-1:0] num_r;
    logic [NUM_W-1:0] quo_r;
    logic [DEN_W-1:0] den_r;
    logic [DEN_W:0]   sh;
    logic [DEN_W+1:0] diff;
    logic             ge;

    // First stage takes the unregistered operands
    if (k == 0) begin : g_src
      assign rem_in = '0;
      assign num_in = num_i;
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_src
      assign rem_in = g_stage[k-1].rem_r;
      assign num_in = g_stage[k-1].num_r;
      assign quo_in = g_stage[k-1].quo_r;
      assign den_in = g_stage[k-1].den_r;
    end

    // Shift in next numerator bit, trial subtract
    always_comb begin
      sh   = {rem_in, num_in[NUM_W-1]};
      diff = {1'b0, sh} - {2'b00, den_in};
      ge   = !diff[DEN_W+1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
        num_r <= {num_in[NUM_W-2:0], 1'b0};
        quo_r <= {quo_in[NUM_W-2:0], ge};
        den_r <= den_in;
      end
    end
  end

  assign quo_o = g_stage[NUM_W-1].quo_r;

endmodule

### hdl/ray_box_slab_test.sv
// Ray against axis-aligned box slab test, top level.
// Pipeline (hit times in Q16.16 at the default FRAC_BITS): one operand stage, a
// FRAC_BITS+33 stage bit-per-stage divider, saturation, ordering, three axis stages.
// Throughput one item per cycle; the whole pipeline holds while the result waits.
// Synchronous active-low reset clears valid bits and box registers to zero.
// Depends on rbst_pkg, rbst_in_if, rbst_out_if, rbst_cfg_if and rbst_div.
module ray_box_slab_test import rbst_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rbst_in_if.sink    in_ch,
  rbst_out_if.source out_ch,
  rbst_cfg_if.sink   cfg_ch
);

  localparam int NUM_W = DATA_W + 1 + FRAC_BITS;
  localparam logic [NUM_W-1:0] Q_MIN_MAG = NUM_W'(64'h8000_0000);
  localparam logic [NUM_W-1:0] Q_MAX_MAG = NUM_W'(64'h7FFF_FFFF);

  logic en;

  // Box registers
  logic signed [DATA_W-1:0] box_lo_r [NUM_AXES];
  logic signed [DATA_W-1:0] box_hi_r [NUM_AXES];

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        box_lo_r[i] <= '0;
        box_hi_r[i] <= '0;
      end
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_MIN_X: box_lo_r[0] <= cfg_ch.data;
        REG_MIN_Y: box_lo_r[1] <= cfg_ch.data;
        REG_MIN_Z: box_lo_r[2] <= cfg_ch.data;
        REG_MAX_X: box_hi_r[0] <= cfg_ch.data;
        REG_MAX_Y: box_hi_r[1] <= cfg_ch.data;
        REG_MAX_Z: box_hi_r[2] <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline moves unless the output is held
  logic out_valid_r;
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // Stage A: differences, magnitudes, signs, zero-direction and in-slab checks
  logic signed [DATA_W-1:0] org [NUM_AXES];
  logic signed [DATA_W-1:0] dir [NUM_AXES];
  assign org[0] = in_ch.origin_x;
  assign org[1] = in_ch.origin_y;
  assign org[2] = in_ch.origin_z;
  assign dir[0] = in_ch.dir_x;
  assign dir[1] = in_ch.dir_y;
  assign dir[2] = in_ch.dir_z;

  logic [NUM_W-1:0]  num_nxt [2*NUM_AXES];
  logic [DATA_W-1:0] den_nxt [2*NUM_AXES];
  logic [NUM_W-1:0]  num_a_r [2*NUM_AXES];
  logic [DATA_W-1:0] den_a_r [2*NUM_AXES];
  side_t             side_nxt;

  always_comb begin
    logic signed [DATA_W:0] diff;
    logic [DATA_W:0]        mag;
    logic [DATA_W-1:0]      dmag;
    side_nxt        = '0;
    side_nxt.valid  = in_ch.valid;
    side_nxt.near_v = in_ch.near_limit;
    side_nxt.far_v  = in_ch.far_limit;
    for (int a = 0; a < NUM_AXES; a++) begin
      side_nxt.zero[a]   = (dir[a] == '0);
      side_nxt.inslab[a] = (org[a] >= box_lo_r[a]) && (org[a] <= box_hi_r[a]);
      dmag = dir[a][DATA_W-1] ? (DATA_W'(0) - dir[a]) : dir[a];
      for (int s = 0; s < 2; s++) begin
        diff = s == 0 ? ({box_lo_r[a][DATA_W-1], box_lo_r[a]} - {org[a][DATA_W-1], org[a]})
                      : ({box_hi_r[a][DATA_W-1], box_hi_r[a]} - {org[a][DATA_W-1], org[a]});
        mag  = diff[DATA_W] ? ((DATA_W+1)'(0) - diff) : diff;
        side_nxt.neg[2*a+s] = diff[DATA_W] ^ dir[a][DATA_W-1];
        num_nxt[2*a+s]      = {mag, {FRAC_BITS{1'b0}}};
        den_nxt[2*a+s]      = dmag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 2*NUM_AXES; i++) begin
        num_a_r[i] <= num_nxt[i];
        den_a_r[i] <= den_nxt[i];
      end
    end
  end

  // Side data shift line, aligned with the dividers
  side_t side_r [0:NUM_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NUM_W; k++) side_r[k].valid <= 1'b0;
    end else if (en) begin
      side_r[0] <= side_nxt;
      for (int k = 1; k <= NUM_W; k++) side_r[k] <= side_r[k-1];
    end
  end

  // Six slab dividers
  logic [NUM_W-1:0] quo [2*NUM_AXES];

  for (genvar i = 0; i < 2*NUM_AXES; i++) begin : g_div
    rbst_div #(.NUM_W(NUM_W), .DEN_W(DATA_W)) u_div (
      .clk   (clk),
      .en    (en),
      .num_i (num_a_r[i]),
      .den_i (den_a_r[i]),
      .quo_o (quo[i])
    );
  end

  // Stage C: sign and saturation
  logic signed [DATA_W-1:0] t_c_r [2*NUM_AXES];
  side_t                    side_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_c_r.valid <= 1'b0;
    end else if (en) begin
      side_c_r <= side_r[NUM_W];
      for (int i = 0; i < 2*NUM_AXES; i++) begin
        if (side_r[NUM_W].neg[i]) begin
          t_c_r[i] <= (quo[i] > Q_MIN_MAG) ? DATA_W'(32'h8000_0000)
                                           : (DATA_W'(0) - quo[i][DATA_W-1:0]);
        end else begin
          t_c_r[i] <= (quo[i] > Q_MAX_MAG) ? DATA_W'(32'h7FFF_FFFF) : quo[i][DATA_W-1:0];
        end
      end
    end
  end

  // Axis stages: index 0 is the ordering stage, j+1 the result after axis j
  logic                     ax_valid_r  [0:NUM_AXES];
  logic                     ax_ok_r     [0:NUM_AXES];
  logic signed [DATA_W-1:0] ax_nr_r     [0:NUM_AXES];
  logic signed [DATA_W-1:0] ax_fr_r     [0:NUM_AXES];
  logic signed [DATA_W-1:0] ax_t0_r     [0:NUM_AXES][NUM_AXES];
  logic signed [DATA_W-1:0] ax_t1_r     [0:NUM_AXES][NUM_AXES];
  logic [NUM_AXES-1:0]      ax_zero_r   [0:NUM_AXES];
  logic [NUM_AXES-1:0]      ax_inslab_r [0:NUM_AXES];

  // Stage D: order each slab pair
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_valid_r[0] <= 1'b0;
    end else if (en) begin
      ax_valid_r[0]  <= side_c_r.valid;
      ax_ok_r[0]     <= 1'b1;
      ax_nr_r[0]     <= side_c_r.near_v;
      ax_fr_r[0]     <= side_c_r.far_v;
      ax_zero_r[0]   <= side_c_r.zero;
      ax_inslab_r[0] <= side_c_r.inslab;
      for (int a = 0; a < NUM_AXES; a++) begin
        if (t_c_r[2*a] < t_c_r[2*a+1]) begin
          ax_t0_r[0][a] <= t_c_r[2*a];
          ax_t1_r[0][a] <= t_c_r[2*a+1];
        end else begin
          ax_t0_r[0][a] <= t_c_r[2*a+1];
          ax_t1_r[0][a] <= t_c_r[2*a];
        end
      end
    end
  end

  for (genvar j = 0; j < NUM_AXES; j++) begin : g_axis
    logic signed [DATA_W-1:0] nr_nxt;
    logic signed [DATA_W-1:0] fr_nxt;
    logic                     ok_nxt;

    // Narrow the interval by one axis
    always_comb begin
      if (ax_zero_r[j][j]) begin
        nr_nxt = ax_nr_r[j];
        fr_nxt = ax_fr_r[j];
        ok_nxt = ax_ok_r[j] && ax_inslab_r[j][j] && (fr_nxt > nr_nxt);
      end else begin
        nr_nxt = (ax_t0_r[j][j] > ax_nr_r[j]) ? ax_t0_r[j][j] : ax_nr_r[j];
        fr_nxt = (ax_t1_r[j][j] < ax_fr_r[j]) ? ax_t1_r[j][j] : ax_fr_r[j];
        ok_nxt = ax_ok_r[j] && (fr_nxt > nr_nxt);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ax_valid_r[j+1] <= 1'b0;
      end else if (en) begin
        ax_valid_r[j+1]  <= ax_valid_r[j];
        ax_ok_r[j+1]     <= ok_nxt;
        ax_nr_r[j+1]     <= nr_nxt;
        ax_fr_r[j+1]     <= fr_nxt;
        ax_zero_r[j+1]   <= ax_zero_r[j];
        ax_inslab_r[j+1] <= ax_inslab_r[j];
        ax_t0_r[j+1]     <= ax_t0_r[j];
        ax_t1_r[j+1]     <= ax_t1_r[j];
      end
    end
  end

  assign out_valid_r   = ax_valid_r[NUM_AXES];
  assign out_ch.valid  = out_valid_r;
  assign out_ch.is_hit = ax_ok_r[NUM_AXES];

  // Assertions
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result valid after reset");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(ax_ok_r[NUM_AXES])))
    else $error("held result changed");

  a_bad_index_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_ch.valid && cfg_ch.index != REG_MIN_X && cfg_ch.index != REG_MIN_Y &&
     cfg_ch.index != REG_MIN_Z && cfg_ch.index != REG_MAX_X &&
     cfg_ch.index != REG_MAX_Y && cfg_ch.index != REG_MAX_Z)
    |=> ($stable(box_lo_r[0]) && $stable(box_lo_r[1]) && $stable(box_lo_r[2]) &&
         $stable(box_hi_r[0]) && $stable(box_hi_r[1]) && $stable(box_hi_r[2])))
    else $error("box changed on unknown register index");

endmodule
